// ===== hw/rtl/permutation_enumerator_core_assert.svh =====
// Assertion macros used by the permutation enumerator RTL.
// Each macro takes a label, a clock, a reset, and two expressions.
`ifndef PERMUTATION_ENUMERATOR_CORE_ASSERT_SVH
`define PERMUTATION_ENUMERATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define PE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("permutation enumerator assertion failed");

// Next-cycle implication.
`define PE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("permutation enumerator assertion failed");

`endif

// ===== hw/rtl/pe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_pkg
// Types and constants of the lexicographic permutation enumerator.
// ----------------------------------------------------------------------------
package pe_pkg;

  localparam int ELEM_W     = 5;
  localparam int CFG_W      = 5;
  localparam int RESULT_CAP = 16;
  localparam logic [CFG_W-1:0] SIZE_RESET = 5'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FIND_RD,
    S_FIND_CHK,
    S_SWAP_A,
    S_SWAP_B,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_DONE_OUT
  } pe_state_t;

endpackage

// ===== hw/rtl/pe_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_req_if
// Request channel: one word asks for the next permutation or a restart.
// ----------------------------------------------------------------------------
interface pe_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ===== hw/rtl/pe_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_res_if
// Result channel: one word carries one element of a permutation or a done mark.
// ----------------------------------------------------------------------------
interface pe_res_if import pe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic [ELEM_W-1:0] position;
  logic              last;
  logic              done_res;

  modport source (output valid, output element, output position, output last,
                  output done_res, input ready);
  modport sink (input valid, input element, input position, input last,
                input done_res, output ready);
endinterface

// ===== hw/rtl/permutation_enumerator_core.sv =====
`timescale 1ns / 1ps
// A restart (or the first request) writes the identity into the permutation RAM and then
// emits its elements. A next-permutation request runs a suffix scan, successor search,
// swap, suffix reversal and emission, all paced by the single read port of the permutation
// RAM. A done word is sent without a scan once the sequence is known to be exhausted, and
// after the scan when it finds no ascent.
// One request is in flight at a time. Reset clears control state and sets the size to 4;
// the permutation RAM is not cleared and is always written before it is read.
// ----------------------------------------------------------------------------
// permutation_enumerator_core
// Steps through the permutations of 1..n in lexicographic order, one element per word.
// ----------------------------------------------------------------------------
`include "permutation_enumerator_core_assert.svh"

module permutation_enumerator_core import pe_pkg::*; #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  pe_req_if.sink           req,
  pe_res_if.source         res
);

  localparam int CAP = (MAX_SYMBOLS < RESULT_CAP) ? MAX_SYMBOLS : RESULT_CAP;
  localparam int AW  = $clog2(CAP);

  pe_state_t state, state_next;

  logic [CFG_W-1:0]  set_size;
  logic              started;
  logic              exhausted;
  logic [CFG_W-1:0]  n_sat;
  logic [AW-1:0]     nm1;

  logic [AW-1:0]     idx;
  logic [AW-1:0]     hi;
  logic [AW-1:0]     piv;
  logic [AW-1:0]     jdx;
  logic [ELEM_W-1:0] prev;
  logic [ELEM_W-1:0] pval;
  logic [ELEM_W-1:0] tmp;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ELEM_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [ELEM_W-1:0] mem_rdata;

  logic              res_valid;
  logic [ELEM_W-1:0] res_element;
  logic [ELEM_W-1:0] res_position;
  logic              res_last;
  logic              res_done;

  logic              accept;
  logic              fresh;
  logic              slot_free;
  logic              rev_more;

  // Effective size: zero acts as one, and the count saturates at the capacity.
  assign n_sat = (set_size == '0) ? CFG_W'(1) :
                 ((set_size > CFG_W'(CAP)) ? CFG_W'(CAP) : set_size);
  assign nm1   = AW'(n_sat - CFG_W'(1));

  assign accept    = req.valid && req.ready;
  assign fresh     = req.restart || !started;
  assign slot_free = !res_valid || res.ready;
  assign rev_more  = (idx + AW'(1)) < (hi - AW'(1));

  pe_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CAP)
  ) u_perm_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (fresh) begin
            state_next = S_INIT;
          end else if (exhausted || nm1 == '0) begin
            state_next = S_DONE_OUT;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_INIT: begin
        if (idx == nm1) begin
          state_next = S_EMIT_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (idx == nm1) begin
          state_next = S_SCAN_RD;
        end else if (mem_rdata < prev) begin
          state_next = S_FIND_RD;
        end else if (idx == '0) begin
          state_next = S_DONE_OUT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_FIND_RD: state_next = S_FIND_CHK;
      S_FIND_CHK: begin
        state_next = (mem_rdata > pval) ? S_SWAP_A : S_FIND_RD;
      end
      S_SWAP_A: state_next = S_SWAP_B;
      S_SWAP_B: begin
        state_next = ((piv + AW'(1)) < nm1) ? S_REV_RD_LO : S_EMIT_RD;
      end
      S_REV_RD_LO: state_next = S_REV_RD_HI;
      S_REV_RD_HI: state_next = S_REV_WR_LO;
      S_REV_WR_LO: state_next = S_REV_WR_HI;
      S_REV_WR_HI: state_next = rev_more ? S_REV_RD_LO : S_EMIT_RD;
      S_EMIT_RD:   state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (slot_free) begin
          state_next = (idx == nm1) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_DONE_OUT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control and request ready.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx;
    req.ready = 1'b0;
    case (state)
      S_IDLE: req.ready = 1'b1;
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = ELEM_W'(idx) + ELEM_W'(1);
      end
      S_SCAN_RD, S_FIND_RD, S_EMIT_RD, S_REV_RD_LO: mem_re = 1'b1;
      S_REV_RD_HI: begin
        mem_re    = 1'b1;
        mem_raddr = hi;
      end
      S_SWAP_A: begin
        mem_we    = 1'b1;
        mem_waddr = piv;
        mem_wdata = tmp;
      end
      S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = jdx;
        mem_wdata = pval;
      end
      S_REV_WR_LO: mem_we = 1'b1;
      S_REV_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi;
        mem_wdata = tmp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      set_size  <= SIZE_RESET;
      started   <= 1'b0;
      exhausted <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        set_size  <= cfg_wdata;
        started   <= 1'b0;
        exhausted <= 1'b0;
      end
      if (state == S_IDLE && accept) begin
        if (fresh) begin
          started   <= 1'b1;
          exhausted <= 1'b0;
        end else if (nm1 == '0) begin
          exhausted <= 1'b1;
        end
      end
      if (state == S_SCAN_CHK && idx != nm1 && !(mem_rdata < prev) && idx == '0) begin
        exhausted <= 1'b1;
      end
      if ((state == S_EMIT_OUT || state == S_DONE_OUT) && slot_free) begin
        res_valid <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          idx <= fresh ? '0 : nm1;
        end
      end
      S_INIT: idx <= (idx == nm1) ? '0 : idx + AW'(1);
      S_SCAN_CHK: begin
        if (idx == nm1) begin
          prev <= mem_rdata;
          idx  <= idx - AW'(1);
        end else if (mem_rdata < prev) begin
          piv  <= idx;
          pval <= mem_rdata;
          idx  <= nm1;
        end else if (idx != '0) begin
          prev <= mem_rdata;
          idx  <= idx - AW'(1);
        end
      end
      S_FIND_CHK: begin
        if (mem_rdata > pval) begin
          jdx <= idx;
          tmp <= mem_rdata;
        end else begin
          idx <= idx - AW'(1);
        end
      end
      S_SWAP_B: begin
        idx <= ((piv + AW'(1)) < nm1) ? piv + AW'(1) : '0;
        hi  <= nm1;
      end
      S_REV_RD_HI: tmp <= mem_rdata;
      S_REV_WR_HI: begin
        idx <= rev_more ? idx + AW'(1) : '0;
        hi  <= hi - AW'(1);
      end
      S_EMIT_OUT: begin
        if (slot_free) begin
          res_element  <= mem_rdata;
          res_position <= ELEM_W'(idx) + ELEM_W'(1);
          res_last     <= (idx == nm1);
          res_done     <= 1'b0;
          idx          <= idx + AW'(1);
        end
      end
      S_DONE_OUT: begin
        if (slot_free) begin
          res_element  <= '0;
          res_position <= '0;
          res_last     <= 1'b1;
          res_done     <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid    = res_valid;
  assign res.element  = res_element;
  assign res.position = res_position;
  assign res.last     = res_last;
  assign res.done_res = res_done;

  // A done word never carries an element, and a permutation word always does.
  `PE_ASSERT_NOW(a_done_word, clk, rst, res.valid && res.done_res,
                 res.last && res.element == '0 && res.position == '0)
  `PE_ASSERT_NOW(a_elem_range, clk, rst, res.valid && !res.done_res,
                 res.element != '0 && res.element <= n_sat && res.position != '0)
  // The RAM is never written and read at the same entry in one cycle.
  `PE_ASSERT_NOW(a_no_rw_clash, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr)
  // Only one request is worked on at a time.
  `PE_ASSERT_NEXT(a_one_in_flight, clk, rst, accept, !req.ready)
  `PE_ASSERT_NOW(a_exh_started, clk, rst, exhausted, started)

endmodule

// ===== hw/rtl/pe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pe_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
